>>> rtl/uer_pkg.sv
package uer_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TRIG_W     = 10;
  localparam int unsigned GAP_W      = 20;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned DIST_W     = 16;

  // distance = floor((w*343 + 1000) / 2000) = floor(floor(p/16) / 125)
  localparam int unsigned MM_PRE_SHIFT = 4;
  localparam int unsigned MM_QUOT_W    = TIME_W - MM_PRE_SHIFT;
  localparam int unsigned MM_RECIP_W   = 29;
  localparam int unsigned MM_RECIP_SH  = 35;
  localparam int unsigned MM_PROD_W    = MM_QUOT_W + MM_RECIP_W;

  localparam logic [TIME_W-1:0]     MM_SPEED = 32'd343;
  localparam logic [TIME_W-1:0]     MM_ROUND = 32'd1000;
  // ceil(2^35 / 125), exact for any 28-bit dividend
  localparam logic [MM_RECIP_W-1:0] MM_RECIP = 29'd274877907;
  localparam logic [DIST_W-1:0]     DIST_MAX = 16'hFFFF;

  localparam logic [TRIG_W-1:0] TRIG_PULSE_RST   = 10'd10;
  localparam logic [GAP_W-1:0]  ECHO_TIMEOUT_RST = 20'd30000;
  localparam logic [GAP_W-1:0]  QUIET_GAP_RST    = 20'd60000;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_EDGE  = 2'd1,
    OP_POLL  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TRIG  = 3'd1,
    PH_RISE  = 3'd2,
    PH_FALL  = 3'd3,
    PH_QUIET = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_STALE   = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIG_PULSE   = 2'd0,
    CFG_ECHO_TIMEOUT = 2'd1,
    CFG_QUIET_GAP    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [TRIG_W-1:0] trigger_pulse_us;
    logic [GAP_W-1:0]  echo_timeout_us;
    logic [GAP_W-1:0]  quiet_gap_us;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic              echo_level;
    logic [TIME_W-1:0] time_us;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    phase_t            phase;
    logic              trigger_drive;
    logic [TIME_W-1:0] echo_width_us;
    logic              reading_valid;
    logic [TIME_W-1:0] timeout_total;
    logic              dist_upd;
  } fsm_res_t;

endpackage

>>> rtl/uer_if.sv
interface uer_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic                       echo_level;
  logic [uer_pkg::TIME_W-1:0] time_us;

  modport source (output valid, opcode, echo_level, time_us, input ready);
  modport sink (input valid, opcode, echo_level, time_us, output ready);
endinterface

interface uer_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [2:0]                 phase;
  logic                       trigger_drive;
  logic [uer_pkg::DIST_W-1:0] range_mm;
  logic [uer_pkg::TIME_W-1:0] echo_width_us;
  logic                       reading_valid;
  logic [uer_pkg::TIME_W-1:0] timeout_total;

  modport source (output valid, status, phase, trigger_drive, range_mm, echo_width_us,
                  reading_valid, timeout_total, input ready);
  modport sink (input valid, status, phase, trigger_drive, range_mm, echo_width_us,
                reading_valid, timeout_total, output ready);
endinterface

>>> rtl/uer_fsm.sv
module uer_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  uer_pkg::cfg_t     cfg,
  input  uer_pkg::in_item_t item,
  input  logic              step,
  output uer_pkg::fsm_res_t res
);

  uer_pkg::phase_t               phase_r, phase_nxt;
  logic [uer_pkg::TIME_W-1:0]    phase_start_r, phase_start_nxt;
  logic [uer_pkg::TIME_W-1:0]    rise_time_r, rise_time_nxt;
  logic [uer_pkg::TIME_W-1:0]    echo_width_r, echo_width_nxt;
  logic                          valid_r, valid_nxt;
  logic [uer_pkg::TIME_W-1:0]    tmo_cnt_r, tmo_cnt_nxt;

  logic [uer_pkg::TIME_W-1:0]    elapsed;
  logic go_trig, go_fall, go_meas, go_rise, go_tmo, go_idle;

  always_comb begin
    elapsed = item.time_us - phase_start_r;
    go_trig = 1'b0;
    go_fall = 1'b0;
    go_meas = 1'b0;
    go_rise = 1'b0;
    go_tmo  = 1'b0;
    go_idle = 1'b0;
    case (item.opcode)
      uer_pkg::OP_START: begin
        go_trig = (phase_r == uer_pkg::PH_IDLE);
      end
      uer_pkg::OP_EDGE: begin
        go_fall = (phase_r == uer_pkg::PH_RISE) && item.echo_level;
        go_meas = (phase_r == uer_pkg::PH_FALL) && !item.echo_level;
      end
      uer_pkg::OP_POLL: begin
        go_rise = (phase_r == uer_pkg::PH_TRIG) &&
                  (elapsed >= uer_pkg::TIME_W'(cfg.trigger_pulse_us));
        go_tmo  = ((phase_r == uer_pkg::PH_RISE) || (phase_r == uer_pkg::PH_FALL)) &&
                  (elapsed >= uer_pkg::TIME_W'(cfg.echo_timeout_us));
        go_idle = (phase_r == uer_pkg::PH_QUIET) &&
                  (elapsed >= uer_pkg::TIME_W'(cfg.quiet_gap_us));
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    phase_nxt       = phase_r;
    phase_start_nxt = phase_start_r;
    rise_time_nxt   = rise_time_r;
    echo_width_nxt  = echo_width_r;
    valid_nxt       = valid_r;
    tmo_cnt_nxt     = tmo_cnt_r;
    if (go_trig) begin
      phase_nxt       = uer_pkg::PH_TRIG;
      phase_start_nxt = item.time_us;
      valid_nxt       = 1'b0;
      echo_width_nxt  = '0;
    end else if (go_fall) begin
      phase_nxt       = uer_pkg::PH_FALL;
      phase_start_nxt = item.time_us;
      rise_time_nxt   = item.time_us;
    end else if (go_meas) begin
      phase_nxt       = uer_pkg::PH_QUIET;
      phase_start_nxt = item.time_us;
      echo_width_nxt  = item.time_us - rise_time_r;
      valid_nxt       = 1'b1;
    end else if (go_rise) begin
      phase_nxt       = uer_pkg::PH_RISE;
      phase_start_nxt = item.time_us;
    end else if (go_tmo) begin
      phase_nxt       = uer_pkg::PH_QUIET;
      phase_start_nxt = item.time_us;
      valid_nxt       = 1'b0;
      echo_width_nxt  = '0;
      tmo_cnt_nxt     = tmo_cnt_r + 1'b1;
    end else if (go_idle) begin
      // start time deliberately kept
      phase_nxt = uer_pkg::PH_IDLE;
    end
  end

  // result of the item, taken after the update
  always_comb begin
    res.status = uer_pkg::ST_STALE;
    if (go_tmo) begin
      res.status = uer_pkg::ST_TIMEOUT;
    end else if (go_trig || go_fall || go_meas || go_rise || go_idle) begin
      res.status = uer_pkg::ST_OK;
    end
    res.phase         = phase_nxt;
    res.trigger_drive = (phase_nxt == uer_pkg::PH_TRIG);
    res.echo_width_us = echo_width_nxt;
    res.reading_valid = valid_nxt;
    res.timeout_total = tmo_cnt_nxt;
    res.dist_upd      = go_meas;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= uer_pkg::PH_IDLE;
      phase_start_r <= '0;
      rise_time_r   <= '0;
      echo_width_r  <= '0;
      valid_r       <= 1'b0;
      tmo_cnt_r     <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      phase_start_r <= phase_start_nxt;
      rise_time_r   <= rise_time_nxt;
      echo_width_r  <= echo_width_nxt;
      valid_r       <= valid_nxt;
      tmo_cnt_r     <= tmo_cnt_nxt;
    end
  end

endmodule

>>> rtl/uer_mm.sv
module uer_mm (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv_a,
  input  logic                       upd_a,
  input  logic [uer_pkg::TIME_W-1:0] width_us,
  input  logic                       adv_b,
  output logic [uer_pkg::DIST_W-1:0] range_mm
);

  logic [uer_pkg::TIME_W-1:0]     prod_r, prod_nxt;
  logic                           upd_r;
  logic [uer_pkg::DIST_W-1:0]     dist_r, dist_nxt;
  logic [uer_pkg::MM_PROD_W-1:0]  recip_prod;
  logic [uer_pkg::MM_PROD_W-uer_pkg::MM_RECIP_SH-1:0] quot;

  // product and sum wrap at 32 bits
  assign prod_nxt = uer_pkg::TIME_W'(width_us * uer_pkg::MM_SPEED) + uer_pkg::MM_ROUND;

  always_comb begin
    recip_prod = uer_pkg::MM_PROD_W'(prod_r[uer_pkg::TIME_W-1:uer_pkg::MM_PRE_SHIFT]) *
                 uer_pkg::MM_PROD_W'(uer_pkg::MM_RECIP);
    quot       = recip_prod[uer_pkg::MM_PROD_W-1:uer_pkg::MM_RECIP_SH];
    if (quot > (uer_pkg::MM_PROD_W-uer_pkg::MM_RECIP_SH)'(uer_pkg::DIST_MAX)) begin
      dist_nxt = uer_pkg::DIST_MAX;
    end else begin
      dist_nxt = quot[uer_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      prod_r <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r  <= 1'b0;
      dist_r <= '0;
    end else begin
      if (adv_a) begin
        upd_r <= upd_a;
      end
      if (adv_b && upd_r) begin
        dist_r <= dist_nxt;
      end
    end
  end

  assign range_mm = dist_r;

endmodule

>>> rtl/ultrasonic_echo_ranging_fsm_unit.sv
// Ranging sequencer for one ultrasonic echo sensor. Each item (start, echo edge or timer
// poll, with a microsecond timestamp) yields one result carrying the status and the
// sequencer state after that item. The unit takes one item per clock while the result side is
// not stalled, through an input register, the sequencer decision, the echo width times 343 plus
// rounding, then the divide by 2000 done as a reciprocal multiply with saturation at 65535. The
// sequencer state is updated in the second stage, so consecutive items see each other's effect
// with no gap. Stalls on the result side back up through the stages; empty stages still fill
// while the output waits. Configuration is written through cfg_we/cfg_idx/cfg_wdata only while
// no item is in flight; the user must keep to this, as the unit itself does not enforce it.
module ultrasonic_echo_ranging_fsm_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata,
  uer_in_if.sink                         in_chan,
  uer_out_if.source                      out_chan
);

  uer_pkg::cfg_t     cfg_r;
  uer_pkg::in_item_t s1_item_r;
  uer_pkg::fsm_res_t fsm_res;
  uer_pkg::fsm_res_t s2_res_r, s3_res_r, s4_res_r;
  logic              v1_r, v2_r, v3_r, v4_r;
  logic              en1, en2, en3, en4;
  logic [uer_pkg::DIST_W-1:0] distance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_pulse_us <= uer_pkg::TRIG_PULSE_RST;
      cfg_r.echo_timeout_us  <= uer_pkg::ECHO_TIMEOUT_RST;
      cfg_r.quiet_gap_us     <= uer_pkg::QUIET_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        uer_pkg::CFG_TRIG_PULSE:   cfg_r.trigger_pulse_us <= cfg_wdata[uer_pkg::TRIG_W-1:0];
        uer_pkg::CFG_ECHO_TIMEOUT: cfg_r.echo_timeout_us  <= cfg_wdata[uer_pkg::GAP_W-1:0];
        uer_pkg::CFG_QUIET_GAP:    cfg_r.quiet_gap_us     <= cfg_wdata[uer_pkg::GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // a stage loads when it is empty or its item moves on
  assign en4 = !v4_r || out_chan.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_chan.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_chan.valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_item_r.opcode     <= in_chan.opcode;
      s1_item_r.echo_level <= in_chan.echo_level;
      s1_item_r.time_us    <= in_chan.time_us;
    end
    if (en2) begin
      s2_res_r <= fsm_res;
    end
    if (en3) begin
      s3_res_r <= s2_res_r;
    end
    if (en4) begin
      s4_res_r <= s3_res_r;
    end
  end

  uer_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .item  (s1_item_r),
    .step  (v1_r && en2),
    .res   (fsm_res)
  );

  uer_mm u_mm (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv_a    (en3),
    .upd_a    (v2_r && s2_res_r.dist_upd),
    .width_us (s2_res_r.echo_width_us),
    .adv_b    (en4),
    .range_mm (distance)
  );

  assign out_chan.valid         = v4_r;
  assign out_chan.status        = s4_res_r.status;
  assign out_chan.phase         = s4_res_r.phase;
  assign out_chan.trigger_drive = s4_res_r.trigger_drive;
  assign out_chan.range_mm      = distance;
  assign out_chan.echo_width_us = s4_res_r.echo_width_us;
  assign out_chan.reading_valid = s4_res_r.reading_valid;
  assign out_chan.timeout_total = s4_res_r.timeout_total;

endmodule
